/* rtl/core/saw_pkg.sv */
package saw_pkg;

    localparam int SAW_TANH_ENTRIES = 256;
    localparam int SAW_SAMPLE_BITS  = 24;

    // Gains are unsigned Q4.12.
    localparam int GAIN_BITS = 16;
    localparam int GAIN_FRAC = 12;
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'd4096;

    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [1:0] {
        MODE_SOFT_CLIP = 2'd0,
        MODE_TREBLE    = 2'd1,
        MODE_HARD_CLIP = 2'd2,
        MODE_BYPASS    = 2'd3
    } shaper_mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SHAPER_MODE = 2'd0,
        REG_INPUT_GAIN  = 2'd1,
        REG_OUTPUT_GAIN = 2'd2
    } cfg_reg_t;

endpackage

/* rtl/core/saw_cdiv.sv */
// Signed floor division by a constant: multiply by a truncated reciprocal,
// register the product, then fix the quotient with one compare and add.
module saw_cdiv #(
    parameter int NUM_BITS = 32,
    parameter int DIVISOR  = 10
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [NUM_BITS-1:0] num,
    output logic signed [NUM_BITS-1:0] quo
);

    localparam int MB = NUM_BITS - 1;
    localparam int SH = MB;
    localparam int RW = SH - $clog2(DIVISOR) + 1;
    localparam longint unsigned RECIP_L = (64'd1 << SH) / DIVISOR;
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
    localparam logic [MB-1:0] DIV_M = MB'(DIVISOR);
    localparam logic signed [NUM_BITS-1:0] DIV_LESS1 = NUM_BITS'(DIVISOR - 1);

    logic              neg;
    logic [MB-1:0]     mag;
    logic [MB+RW-1:0]  prod_next;
    logic [MB+RW-1:0]  prod_reg;
    logic [MB-1:0]     mag_reg;
    logic              neg_reg;
    logic [MB-1:0]     q0;
    logic [MB-1:0]     rem;
    logic [MB-1:0]     q1;

    // A negative numerator is divided as ceil(|n| / d) and negated.
    always_comb
    begin
        neg       = num[NUM_BITS-1];
        mag       = neg ? MB'(DIV_LESS1 - num) : MB'(num);
        prod_next = (MB+RW)'(mag) * (MB+RW)'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            mag_reg  <= mag;
            neg_reg  <= neg;
        end
    end

    // The reciprocal is rounded down, so the estimate is short by at most one.
    always_comb
    begin
        q0  = MB'(prod_reg >> SH);
        rem = mag_reg - MB'(q0 * DIV_M);
        q1  = (rem >= DIV_M) ? q0 + MB'(1) : q0;
        quo = neg_reg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    end

endmodule

/* rtl/core/selectable_audio_waveshaper_unit.sv */
// Selectable audio waveshaper.
// Input channel: in_valid / in_stall with sample_in, a signed Q1.23 sample.
// Output channel: out_valid / out_stall with sample_out and saturated.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// is the shaper mode, 1 the input gain, 2 the output gain (Q4.12). Writes to
// index 3 are dropped. cfg_ready is always high; change registers only while
// no item is in flight.
// Each accepted item produces exactly one result item. The datapath is a
// 12-stage pipeline, so one item is taken every cycle unless it holds; the
// depth is set by the gain multipliers, the interpolated tanh table and
// three constant dividers, each of which takes a stage for its product.
// When out_stall is high while a result waits, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and sets the mode to soft clip and both gains
// to unity. The tanh table is a constant built at elaboration, so no
// initialization pass follows reset.
module selectable_audio_waveshaper_unit
    import saw_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = SAW_TANH_ENTRIES,
    parameter int SAMPLE_BITS        = SAW_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [GAIN_BITS-1:0]          cfg_data
);

    localparam int F      = SAMPLE_BITS - 1;
    localparam int N      = TANH_TABLE_ENTRIES;
    localparam int IB     = $clog2(N + 1);
    localparam int PW1    = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int XW     = SAMPLE_BITS + 5;
    localparam int AW     = SAMPLE_BITS + 7;
    localparam int PSW    = IB + F + 2;
    localparam int FRB    = 16;
    localparam int PW3    = F + FRB + 2;
    localparam int TW     = F + 2;
    localparam int NW1    = F + 6;
    localparam int V1W    = F + 3;
    localparam int NW2    = F + 8;
    localparam int NW3    = XW + 3;
    localparam int Y3W    = F + 4;
    localparam int PW10   = Y3W + GAIN_BITS + 1;
    localparam int OW     = PW10 - GAIN_FRAC;
    localparam int STAGES = 12;
    localparam int LAST   = STAGES - 1;

    localparam int DIV_TANH   = 50;
    localparam int DIV_TREBLE = 10;
    localparam int DIV_SCALE  = 10;

    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint ONE_L  = longint'(1) << F;
    localparam longint C09_L  = (18 * ONE_L + 10) / 20;
    localparam longint C08_L  = (16 * ONE_L + 10) / 20;
    localparam longint C05_L  = ONE_L / 2;

    localparam logic signed [PW1-1:0]  GAIN_HALF1 = PW1'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [PW10-1:0] GAIN_HALF2 = PW10'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [PW3-1:0]  FR_HALF    = PW3'(1) <<< (FRB - 1);
    localparam logic signed [TW-1:0]   T_ONE      = TW'(ONE_L);
    localparam logic signed [NW1-1:0]  K25        = NW1'(25);
    localparam logic signed [V1W-1:0]  V1_LIM     = V1W'(2 * ONE_L);
    localparam logic signed [NW2-1:0]  K52        = NW2'(52);
    localparam logic signed [NW2-1:0]  K5_2       = NW2'(5);
    localparam logic signed [NW2-1:0]  C09_2      = NW2'(C09_L);
    localparam logic signed [XW-1:0]   C08_X      = XW'(C08_L);
    localparam logic signed [XW-1:0]   C05_X      = XW'(C05_L);
    localparam logic signed [NW3-1:0]  K5_3       = NW3'(5);
    localparam logic signed [OW-1:0]   S_MAX      = OW'(ONE_L - 1);
    localparam logic signed [OW-1:0]   S_MIN      = -OW'(ONE_L);

    typedef logic [N:0][F-1:0] rom_t;

    // Unsigned quotient by shift and subtract, used only while the table is
    // built at elaboration.
    function automatic longint unsigned long_udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh over [0, 4] at N+1 points: (1 - s) / (1 + s) with s = exp(-8i/N),
    // s from a Taylor series at a sixteenth of the argument, squared 4 times.
    function automatic rom_t build_rom();
        rom_t              rom;
        longint unsigned   y;
        longint unsigned   term;
        longint unsigned   s;
        longint            sum;
        for (int i = 0; i <= N; i++)
        begin
            y    = long_udiv(longint'(i) << 29, longint'(N));
            term = Q30;
            sum  = longint'(Q30);
            for (int k = 1; k <= 12; k++)
            begin
                term = long_udiv((term * y) >> 30, longint'(k));
                if ((k & 1) != 0)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            s = longint'(sum);
            for (int k = 0; k < 4; k++)
                s = (s * s) >> 30;
            rom[i] = F'(long_udiv((Q30 - s) << F, Q30 + s));
        end
        return rom;
    endfunction

    localparam rom_t TANH_ROM = build_rom();

    // Configuration registers.
    shaper_mode_t          shaper_mode_reg;
    logic [GAIN_BITS-1:0]  input_gain_reg;
    logic [GAIN_BITS-1:0]  output_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shaper_mode_reg <= MODE_SOFT_CLIP;
            input_gain_reg  <= GAIN_UNITY;
            output_gain_reg <= GAIN_UNITY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHAPER_MODE: shaper_mode_reg <= shaper_mode_t'(cfg_data[1:0]);
                REG_INPUT_GAIN:  input_gain_reg  <= cfg_data;
                REG_OUTPUT_GAIN: output_gain_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // The pipeline advances as a whole unless the finished item is held.
    logic              en;
    logic [STAGES-1:0] vld_reg;

    assign en       = !(vld_reg[LAST] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
    end

    // Stage 0: input gain product.
    logic signed [PW1-1:0] p1_next;
    logic signed [PW1-1:0] p1_reg;

    assign p1_next = sample_in * $signed({1'b0, input_gain_reg});

    // Stage 1: gained sample, tanh argument split into table index and fraction.
    logic signed [PW1-1:0] p1_rnd;
    logic signed [XW-1:0]  x1_next;
    logic signed [AW-1:0]  x_ext;
    logic signed [AW-1:0]  arg;
    logic [AW-1:0]         arg_mag;
    logic                  big1_next;
    logic [PSW-1:0]        pos;
    logic signed [XW-1:0]  x1_reg;
    logic [IB-1:0]         idx1_reg;
    logic [FRB-1:0]        fr1_reg;
    logic                  big1_reg;
    logic                  neg1_reg;

    always_comb
    begin
        p1_rnd    = p1_reg + GAIN_HALF1;
        x1_next   = XW'(p1_rnd >>> GAIN_FRAC);
        x_ext     = AW'(x1_next);
        arg       = (shaper_mode_reg == MODE_SOFT_CLIP) ? (x_ext <<< 2) + x_ext : x_ext;
        arg_mag   = arg[AW-1] ? -arg : arg;
        // Arguments of 4.0 and beyond take the last table point.
        big1_next = |arg_mag[AW-2:F+2];
        pos       = PSW'(arg_mag[F+1:0]) * PSW'(N);
    end

    // Stage 2: table reads.
    logic signed [XW-1:0] x2_reg;
    logic [F-1:0]         y0_2_reg;
    logic [F-1:0]         y1_2_reg;
    logic [FRB-1:0]       fr2_reg;
    logic                 big2_reg;
    logic                 neg2_reg;

    // Stage 3: slope times fraction.
    logic signed [F:0]     diff;
    logic signed [PW3-1:0] prod3_next;
    logic signed [XW-1:0]  x3_reg;
    logic [F-1:0]          y0_3_reg;
    logic signed [PW3-1:0] prod3_reg;
    logic                  big3_reg;
    logic                  neg3_reg;

    assign diff       = $signed({1'b0, y1_2_reg}) - $signed({1'b0, y0_2_reg});
    assign prod3_next = diff * $signed({1'b0, fr2_reg});

    // Stage 4: interpolated, signed tanh.
    logic signed [TW-1:0] r4;
    logic signed [TW-1:0] t4_next;
    logic signed [XW-1:0] x4_reg;
    logic signed [TW-1:0] t4_reg;

    always_comb
    begin
        if (big3_reg)
            r4 = $signed(TW'(TANH_ROM[N]));
        else
            r4 = $signed(TW'(y0_3_reg)) + TW'((prod3_reg + FR_HALF) >>> FRB);
        t4_next = neg3_reg ? -r4 : r4;
    end

    // Stage 5: 0.32 * tanh through the first divider.
    logic signed [NW1-1:0] div1_num;
    logic signed [NW1-1:0] div1_quo;
    logic signed [XW-1:0]  x5_reg;
    logic signed [TW-1:0]  t5_reg;

    assign div1_num = (NW1'(t4_reg) <<< 4) + K25;

    saw_cdiv #(
        .NUM_BITS(NW1),
        .DIVISOR (DIV_TANH)
    ) u_div_tanh (
        .clk(clk),
        .en (en),
        .num(div1_num),
        .quo(div1_quo)
    );

    // Stage 6: x - 0.32 * tanh(x). The later clamp to +-0.9 is reached well
    // before +-2, so the difference is clamped there to keep it narrow.
    logic signed [XW:0]    v1;
    logic signed [V1W-1:0] v1c_next;
    logic signed [V1W-1:0] v1c6_reg;
    logic signed [XW-1:0]  x6_reg;
    logic signed [TW-1:0]  t6_reg;

    always_comb
    begin
        v1 = (XW+1)'(x5_reg) - (XW+1)'(div1_quo);
        if (v1 > (XW+1)'(V1_LIM))
            v1c_next = V1_LIM;
        else if (v1 < -(XW+1)'(V1_LIM))
            v1c_next = -V1_LIM;
        else
            v1c_next = V1W'(v1);
    end

    // Stage 7: times 5.2 through the second divider.
    logic signed [NW2-1:0] div2_num;
    logic signed [NW2-1:0] div2_quo;
    logic signed [XW-1:0]  x7_reg;
    logic signed [TW-1:0]  t7_reg;

    assign div2_num = NW2'(v1c6_reg) * K52 + K5_2;

    saw_cdiv #(
        .NUM_BITS(NW2),
        .DIVISOR (DIV_TREBLE)
    ) u_div_treble (
        .clk(clk),
        .en (en),
        .num(div2_num),
        .quo(div2_quo)
    );

    // Stage 8: shape selection.
    logic signed [XW-1:0] y8_next;
    logic signed [XW-1:0] y8_reg;

    always_comb
    begin
        case (shaper_mode_reg)
            MODE_SOFT_CLIP:
                y8_next = XW'(t7_reg);
            MODE_TREBLE:
            begin
                if (div2_quo > C09_2)
                    y8_next = XW'(C09_2);
                else if (div2_quo < -C09_2)
                    y8_next = -XW'(C09_2);
                else
                    y8_next = XW'(div2_quo);
            end
            MODE_HARD_CLIP:
            begin
                if (x7_reg > C08_X)
                    y8_next = C08_X;
                else if (x7_reg < -C05_X)
                    y8_next = -C05_X;
                else
                    y8_next = x7_reg;
            end
            default:
                y8_next = x7_reg;
        endcase
    end

    // Stage 9: times 0.4 through the third divider.
    logic signed [NW3-1:0] div3_num;
    logic signed [NW3-1:0] div3_quo;

    assign div3_num = (NW3'(y8_reg) <<< 2) + K5_3;

    saw_cdiv #(
        .NUM_BITS(NW3),
        .DIVISOR (DIV_SCALE)
    ) u_div_scale (
        .clk(clk),
        .en (en),
        .num(div3_num),
        .quo(div3_quo)
    );

    // Stage 10: output gain product.
    logic signed [Y3W-1:0]  y3;
    logic signed [PW10-1:0] prod10_next;
    logic signed [PW10-1:0] prod10_reg;

    assign y3          = Y3W'(div3_quo);
    assign prod10_next = y3 * $signed({1'b0, output_gain_reg});

    // Stage 11: rounding and saturation into the output register.
    logic signed [PW10-1:0]        prod10_rnd;
    logic signed [OW-1:0]          o11;
    logic signed [SAMPLE_BITS-1:0] out_next;
    logic                          sat_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          saturated_reg;

    always_comb
    begin
        prod10_rnd = prod10_reg + GAIN_HALF2;
        o11        = OW'(prod10_rnd >>> GAIN_FRAC);
        if (o11 > S_MAX)
        begin
            out_next = SAMPLE_BITS'(S_MAX);
            sat_next = 1'b1;
        end
        else if (o11 < S_MIN)
        begin
            out_next = SAMPLE_BITS'(S_MIN);
            sat_next = 1'b1;
        end
        else
        begin
            out_next = SAMPLE_BITS'(o11);
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg         <= p1_next;
            x1_reg         <= x1_next;
            idx1_reg       <= pos[PSW-1:F+2];
            fr1_reg        <= pos[F+1 -: FRB];
            big1_reg       <= big1_next;
            neg1_reg       <= arg[AW-1];
            x2_reg         <= x1_reg;
            y0_2_reg       <= TANH_ROM[idx1_reg];
            y1_2_reg       <= TANH_ROM[idx1_reg + IB'(1)];
            fr2_reg        <= fr1_reg;
            big2_reg       <= big1_reg;
            neg2_reg       <= neg1_reg;
            x3_reg         <= x2_reg;
            y0_3_reg       <= y0_2_reg;
            prod3_reg      <= prod3_next;
            big3_reg       <= big2_reg;
            neg3_reg       <= neg2_reg;
            x4_reg         <= x3_reg;
            t4_reg         <= t4_next;
            x5_reg         <= x4_reg;
            t5_reg         <= t4_reg;
            v1c6_reg       <= v1c_next;
            x6_reg         <= x5_reg;
            t6_reg         <= t5_reg;
            x7_reg         <= x6_reg;
            t7_reg         <= t6_reg;
            y8_reg         <= y8_next;
            prod10_reg     <= prod10_next;
            sample_out_reg <= out_next;
            saturated_reg  <= sat_next;
        end
    end

    assign out_valid  = vld_reg[LAST];
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

    // A flagged result is always a full-scale code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            sample_out == SAMPLE_BITS'(S_MAX) || sample_out == SAMPLE_BITS'(S_MIN))
    else $error("saturated result is not full scale");

    // A held pipeline keeps every valid bit in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
    else $error("valid bits moved during a stall");

    // An accepted item enters the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
    else $error("accepted item lost at pipeline entry");

    // Interpolation stays within the table range.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> t4_reg <= T_ONE && t4_reg >= -T_ONE)
    else $error("tanh value out of range");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import saw_pkg::*;

    localparam int SAMPLE_W = SAW_SAMPLE_BITS;
    localparam int TANH_N   = SAW_TANH_ENTRIES;
    localparam int FRAC     = SAMPLE_W - 1;

    localparam longint ONE_Q      = 64'sd1 << FRAC;
    localparam longint LEVEL_MAX  = ONE_Q - 1;
    localparam longint LEVEL_MIN  = -ONE_Q;
    localparam longint Q30        = 64'sd1 << 30;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    // Index 3 has no register behind it; writes there must be dropped.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic signed [SAMPLE_W-1:0] level;
        logic                       clipped;
    } shaped_t;

    class waveshape_scoreboard;
        longint       tanh_rom[TANH_N+1];
        longint       bound_09;
        longint       bound_05;
        longint       bound_08;
        shaper_mode_t mode;
        logic [GAIN_BITS-1:0] in_gain;
        logic [GAIN_BITS-1:0] out_gain;
        shaped_t      expected_q[$];
        int           mismatches;

        function new();
            build_tanh_rom();
            bound_09   = round_div(9 * ONE_Q, 10);
            bound_05   = round_div(ONE_Q, 2);
            bound_08   = round_div(8 * ONE_Q, 10);
            mode       = MODE_SOFT_CLIP;
            in_gain    = GAIN_UNITY;
            out_gain   = GAIN_UNITY;
            mismatches = 0;
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        // Half-up rounding of n/d, ties toward +infinity.
        function longint round_div(longint n, longint d);
            return floor_div(2 * n + d, 2 * d);
        endfunction

        function longint clamp_level(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // exp(-8i/N) in Q30 from a Taylor series at 1/16 of the argument,
        // squared four times, then tanh = (1-s)/(1+s).
        function void build_tanh_rom();
            longint y;
            longint term;
            longint sum;
            longint s;
            for (int i = 0; i <= TANH_N; i++)
            begin
                y    = (longint'(i) << 29) / TANH_N;
                term = Q30;
                sum  = Q30;
                for (int k = 1; k <= 12; k++)
                begin
                    term = ((term * y) >>> 30) / k;
                    sum  = (k % 2 == 1) ? sum - term : sum + term;
                end
                s = sum;
                for (int k = 0; k < 4; k++)
                    s = (s * s) >>> 30;
                tanh_rom[i] = ((Q30 - s) << FRAC) / (Q30 + s);
            end
        endfunction

        function longint tanh_lookup(longint arg);
            longint mag;
            longint pos;
            longint idx;
            longint frac_pos;
            longint r;
            mag = (arg < 0) ? -arg : arg;
            pos = mag * TANH_N;
            if (pos >= (longint'(TANH_N) << (FRAC + 2)))
                r = tanh_rom[TANH_N];
            else
            begin
                idx      = pos >>> (FRAC + 2);
                frac_pos = (pos & ((64'sd1 << (FRAC + 2)) - 1)) >>> (FRAC + 2 - 16);
                r = tanh_rom[int'(idx)]
                    + round_div((tanh_rom[int'(idx) + 1] - tanh_rom[int'(idx)]) * frac_pos,
                                64'sd65536);
            end
            return (arg < 0) ? -r : r;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [GAIN_BITS-1:0] data);
            if (idx == REG_SHAPER_MODE)
                mode = shaper_mode_t'(data[1:0]);
            else if (idx == REG_INPUT_GAIN)
                in_gain = data;
            else if (idx == REG_OUTPUT_GAIN)
                out_gain = data;
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] smp);
            longint  x;
            longint  y;
            longint  v;
            shaped_t res;
            x = round_div(longint'(smp) * longint'(in_gain), 4096);
            case (mode)
                MODE_SOFT_CLIP: y = tanh_lookup(5 * x);
                MODE_TREBLE:
                begin
                    v = x - round_div(tanh_lookup(x) * 8, 25);
                    v = round_div(v * 26, 5);
                    y = clamp_level(v, -bound_09, bound_09);
                end
                MODE_HARD_CLIP: y = clamp_level(x, -bound_05, bound_08);
                default:        y = x;
            endcase
            y = round_div(y * 2, 5);
            y = round_div(y * longint'(out_gain), 4096);
            res.clipped = 1'b0;
            if (y > LEVEL_MAX)
            begin
                y = LEVEL_MAX;
                res.clipped = 1'b1;
            end
            else if (y < LEVEL_MIN)
            begin
                y = LEVEL_MIN;
                res.clipped = 1'b1;
            end
            res.level = y[SAMPLE_W-1:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] level, logic clipped);
            shaped_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result item with none pending: sample_out %0d saturated %0b",
                         $time, level, clipped);
                return;
            end
            want = expected_q.pop_front();
            if (level !== want.level)
            begin
                mismatches++;
                $display("%0t: sample_out expected %0d actual %0d", $time, want.level, level);
            end
            if (clipped !== want.clipped)
            begin
                mismatches++;
                $display("%0t: saturated expected %0b actual %0b", $time, want.clipped, clipped);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample_in;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic                        saturated;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [GAIN_BITS-1:0]        cfg_data;

    waveshape_scoreboard sb;

    selectable_audio_waveshaper_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .saturated  (saturated),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("selectable_audio_waveshaper_unit verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(sample_in);
            if (out_valid && !out_stall)
                sb.check_result(sample_out, saturated);
        end
    end

    // Receiver back-pressure: switches between free flow, light and heavy
    // random stalls, and occasional long stall bursts.
    initial
    begin
        int style;
        int span;
        int hold;
        out_stall = 1'b0;
        hold      = 0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(40, 300);
            repeat (span)
            begin
                @(negedge clk);
                case (style)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 3) == 0);
                    2: out_stall = ($urandom_range(0, 9) < 6);
                    default:
                    begin
                        if (hold > 0)
                        begin
                            out_stall = 1'b1;
                            hold--;
                        end
                        else
                        begin
                            out_stall = 1'b0;
                            if ($urandom_range(0, 15) == 0)
                                hold = $urandom_range(3, 20);
                        end
                    end
                endcase
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0:       return r[0] ? SAMPLE_MAX : SAMPLE_MIN;
            1:       return {{12{r[11]}}, r[11:0]};
            2:       return {{4{r[19]}}, r[19:0]};
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0:       return GAIN_UNITY;
            1:       return '0;
            2:       return '1;
            3:       return {2'b00, r[13:0]};
            default: return r[GAIN_BITS-1:0];
        endcase
    endfunction

    task automatic send_item(input logic signed [SAMPLE_W-1:0] smp);
        @(negedge clk);
        in_valid  = 1'b1;
        sample_in = smp;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic pause(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid  = 1'b0;
            sample_in = SAMPLE_W'($urandom());
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [GAIN_BITS-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Registers change only once the pipeline has emptied.
    task automatic configure(input shaper_mode_t md, input logic [GAIN_BITS-1:0] ig,
                             input logic [GAIN_BITS-1:0] og);
        logic [31:0] r;
        pause(1);
        wait_drained();
        repeat (4) @(posedge clk);
        r = $urandom();
        reg_write(REG_SHAPER_MODE, {r[15:2], md});
        reg_write(REG_INPUT_GAIN, ig);
        reg_write(REG_OUTPUT_GAIN, og);
        if (r[16])
            reg_write(REG_UNMAPPED, r[31:16]);
    endtask

    initial
    begin
        int           sent;
        int           burst;
        int           goal;
        bit           drained_once;
        shaper_mode_t md;

        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        drained_once = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: soft clip at unity gains, including the region past
        // the end of the tanh table.
        send_item(SAMPLE_MAX);
        send_item(SAMPLE_MIN);
        send_item(24'sd0);
        send_item(24'sd1);
        send_item(-24'sd1);
        send_item(24'sd4194304);
        send_item(-24'sd4194304);

        pause(1);
        wait_drained();
        reg_write(REG_UNMAPPED, GAIN_BITS'($urandom()));
        configure(MODE_TREBLE, GAIN_UNITY, GAIN_UNITY);
        send_item(SAMPLE_MAX);
        send_item(SAMPLE_MIN);
        send_item(24'sd2684354);
        send_item(-24'sd1);

        configure(MODE_HARD_CLIP, 16'hFFFF, GAIN_UNITY);
        send_item(SAMPLE_MAX);
        send_item(SAMPLE_MIN);
        send_item(24'sd1000000);
        send_item(-24'sd700000);

        // Bypass with full output gain drives the final saturation both ways.
        configure(MODE_BYPASS, GAIN_UNITY, 16'hFFFF);
        send_item(SAMPLE_MAX);
        send_item(SAMPLE_MIN);
        send_item(24'sd3000000);
        send_item(24'sd1);

        configure(MODE_SOFT_CLIP, 16'h0000, 16'h0000);
        send_item(SAMPLE_MAX);
        send_item(-24'sd1);

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: configure(MODE_SOFT_CLIP, 16'hFFFF, GAIN_UNITY);
                1: configure(MODE_TREBLE, 16'h0000, 16'hFFFF);
                2: configure(MODE_HARD_CLIP, 16'hFFFF, 16'hFFFF);
                3: configure(MODE_BYPASS, GAIN_UNITY, 16'h0000);
                default:
                begin
                    md = shaper_mode_t'($urandom_range(0, 3));
                    configure(md, pick_gain(), pick_gain());
                end
            endcase
            goal = 155;
            sent = 0;
            while (sent < goal)
            begin
                burst = $urandom_range(1, 24);
                if (burst > goal - sent)
                    burst = goal - sent;
                repeat (burst) send_item(pick_sample());
                sent += burst;
                case ($urandom_range(0, 7))
                    0, 1, 2: ;
                    7:       pause($urandom_range(10, 40));
                    default: pause($urandom_range(1, 6));
                endcase
                // Hold the sender off once until the pipeline has emptied.
                if (phase == 5 && !drained_once && sent >= goal / 2)
                begin
                    pause(1);
                    wait_drained();
                    drained_once = 1'b1;
                end
            end
        end

        pause(1);
        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("selectable_audio_waveshaper_unit verification clean");
        else
            $display("selectable_audio_waveshaper_unit verification failed");
        $finish;
    end

endmodule
